@@ rtl/brgs_pkg.sv @@
// Package with the shared types and constants of the group scheduler.
`timescale 1ns / 1ps
package brgs_pkg;

	localparam int MAX_HANDLES = 2048;
	localparam int GROUP_SIZE  = 32;
	localparam int NUM_GROUPS  = MAX_HANDLES / GROUP_SIZE;
	localparam int HW          = $clog2(MAX_HANDLES);
	localparam int PTR_W       = HW + 1;
	localparam int GW          = $clog2(NUM_GROUPS);
	localparam int CW          = $clog2(GROUP_SIZE) + 1;
	localparam int WW          = GW + 1;
	localparam int SUM_W       = PTR_W + 1;
	localparam int SCHED_W     = 12;
	localparam int FPS_W       = 12;
	localparam int MUL_W       = 16;

	// Frame rate thresholds in UQ8.4 and the exact divide-by-ten reciprocal.
	localparam logic [FPS_W-1:0] FPS_LO  = 12'd80;
	localparam logic [FPS_W-1:0] FPS_MID = 12'd160;
	localparam logic [FPS_W-1:0] FPS_HI  = 12'd320;
	localparam int DIV10_MUL = 52429;
	localparam int DIV10_SH  = 19;

	localparam logic [SCHED_W-1:0] SCHED_RESET = 12'd200;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_QUERY   = 2'd3
	} op_e;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_BAD_REL = 2'd2;

	typedef struct packed {
		logic [1:0]       operation;
		logic [HW-1:0]    handle;
		logic [FPS_W-1:0] fps_x16;
	} in_t;

	typedef struct packed {
		logic [HW-1:0]      new_handle;
		logic               skip;
		logic [6:0]         selected_groups;
		logic [SCHED_W-1:0] budget;
		logic [1:0]         status;
	} out_t;

	typedef struct packed {
		logic accept;
		logic alloc_rd;
		logic alloc_cnt;
		logic alloc_wr;
		logic rel_rd;
		logic rel_wr;
		logic upd_mul;
		logic upd_div;
		logic walk_issue;
		logic walk_upd;
		logic walk_adv;
		logic query;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_op;
		logic       empty;
		logic       adv_need;
		logic       walk_done;
	} sts_t;

endpackage

@@ rtl/budgeted_round_robin_group_scheduler.sv @@
// Operations are query, allocate (which ends early when the free stack is empty), release,
// which goes on to seek the next live group of higher id when the cursor's group empties,
// and update, which walks the groups through the group counter memory read port.
// One item at a time; busy is low in the cycle the done beat is shown.
// The receiver cannot stall. Asynchronous reset restores an empty allocation, schedule
// count 200 and the cursor at its end; no clearing pass is needed.
`timescale 1ns / 1ps
module budgeted_round_robin_group_scheduler import brgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_t                item,
	output logic               done,
	output out_t               result,
	input  logic               cfg_we,
	input  logic [SCHED_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	brgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	brgs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

@@ rtl/brgs_dp.sv @@
// Datapath: free stack, handle marks, group counters, budget and group walk.
`timescale 1ns / 1ps
module brgs_dp import brgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  in_t                item,
	input  logic               cfg_we,
	input  logic [SCHED_W-1:0] cfg_wdata,
	input  cmd_t               cmd,
	output sts_t               sts,
	output out_t               result
);

	logic [HW-1:0]    stack_mem [MAX_HANDLES];
	logic             mark_mem  [MAX_HANDLES];
	logic [CW-1:0]    cnt_mem   [NUM_GROUPS];

	in_t                item_q;
	out_t               res_q;
	logic [SCHED_W-1:0] sched_q;
	logic [PTR_W-1:0]   ptr_q, hw_q;
	logic [GW-1:0]      cursor_q;
	logic               at_end_q;
	logic [NUM_GROUPS-1:0] sel_q, cnt_vld_q;
	logic [WW-1:0]      wcnt_q, wlim_q;
	logic [GW-1:0]      wbase_q;
	logic               wvld_s1, wlast_s1;
	logic [GW-1:0]      wgrp_s1;
	logic [SUM_W-1:0]   sum_q;
	logic [6:0]         marked_q;
	logic [SCHED_W-1:0] budget_q;
	logic [MUL_W-1:0]   mul_s1;
	logic [HW-1:0]      alloc_h_q, stack_rd_q;
	logic               hit_q, mvld_q, mark_rd_q;
	logic [CW-1:0]      cnt_rd_q;
	logic               cnt_rv_q;

	logic [GW-1:0]      g_rel, g_alloc, walk_addr, cnt_raddr, cnt_waddr;
	logic [HW-1:0]      alloc_a;
	logic [CW-1:0]      cval, rel_newc, cnt_wdata;
	logic               cnt_we, rel_ok, live, over, walk_go;
	logic [SUM_W-1:0]   sum_nxt;
	logic [PTR_W-1:0]   ptr_m1;
	logic [3:0]         fac;
	logic [2*MUL_W:0]   dprod;
	logic [SCHED_W-1:0] bud_nxt;

	// Address and operand selection.
	assign g_rel     = item_q.handle[HW-1 -: GW];
	assign alloc_a   = hit_q ? stack_rd_q : ptr_q[HW-1:0];
	assign g_alloc   = alloc_h_q[HW-1 -: GW];
	assign cval      = cnt_rv_q ? cnt_rd_q : '0;
	assign live      = (cval != '0);
	assign rel_ok    = mvld_q & mark_rd_q;
	assign rel_newc  = live ? cval - CW'(1) : cval;
	assign walk_addr = wbase_q + wcnt_q[GW-1:0];
	assign walk_go   = cmd.walk_issue && (wcnt_q < wlim_q);
	assign sum_nxt   = sum_q + SUM_W'(cval);
	assign over      = sum_nxt > SUM_W'(budget_q);
	assign ptr_m1    = ptr_q - PTR_W'(1);

	always_comb begin
		priority if (cmd.alloc_cnt) begin
			cnt_raddr = alloc_a[HW-1 -: GW];
		end else if (cmd.rel_rd) begin
			cnt_raddr = g_rel;
		end else begin
			cnt_raddr = walk_addr;
		end
	end

	// Counter write port: increment on allocate, decrement on a good release.
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = g_alloc;
		cnt_wdata = cval + CW'(1);
		if (cmd.alloc_wr) begin
			cnt_we = 1'b1;
		end else if (cmd.rel_wr && rel_ok) begin
			cnt_we    = 1'b1;
			cnt_waddr = g_rel;
			cnt_wdata = rel_newc;
		end
	end

	// Budget scale factor in tenths.
	always_comb begin
		priority if (item_q.fps_x16 < FPS_LO) begin
			fac = 4'd3;
		end else if (item_q.fps_x16 < FPS_MID) begin
			fac = 4'd6;
		end else if (item_q.fps_x16 < FPS_HI) begin
			fac = 4'd9;
		end else begin
			fac = 4'd10;
		end
	end

	assign dprod   = (2*MUL_W+1)'(mul_s1) * (2*MUL_W+1)'(DIV10_MUL);
	assign bud_nxt = dprod[DIV10_SH +: SCHED_W];

	// Status back to the controller.
	always_comb begin
		sts.in_op     = item.operation;
		sts.empty     = ptr_q[PTR_W-1];
		sts.adv_need  = cmd.rel_wr && rel_ok && (rel_newc == '0) && !at_end_q &&
			(cursor_q == g_rel) && (g_rel != '1);
		sts.walk_done = wvld_s1 && ((cmd.walk_upd && ((live && over) || wlast_s1)) ||
			(cmd.walk_adv && (live || wlast_s1)));
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q   <= SCHED_RESET;
			ptr_q     <= '0;
			hw_q      <= '0;
			cursor_q  <= '0;
			at_end_q  <= 1'b1;
			sel_q     <= '0;
			cnt_vld_q <= '0;
			wcnt_q    <= '0;
			wlim_q    <= '0;
			wbase_q   <= '0;
			wvld_s1   <= 1'b0;
			sum_q     <= '0;
			marked_q  <= '0;
			hit_q     <= 1'b0;
			mvld_q    <= 1'b0;
			cnt_rv_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				sched_q <= cfg_wdata;
			end
			cnt_rv_q <= cnt_vld_q[cnt_raddr];
			wvld_s1  <= walk_go;
			if (walk_go) begin
				wcnt_q <= wcnt_q + WW'(1);
			end
			if (cmd.alloc_rd) begin
				hit_q <= (ptr_q < hw_q);
			end
			if (cmd.alloc_wr) begin
				ptr_q <= ptr_q + PTR_W'(1);
				if (!hit_q) begin
					hw_q <= ptr_q + PTR_W'(1);
				end
				cnt_vld_q[g_alloc] <= 1'b1;
			end
			if (cmd.rel_rd) begin
				mvld_q <= (PTR_W'(item_q.handle) < hw_q);
			end
			// A good release may empty the cursor's group and move the cursor on.
			if (cmd.rel_wr && rel_ok) begin
				ptr_q <= ptr_m1;
				cnt_vld_q[g_rel] <= 1'b1;
				if ((rel_newc == '0) && !at_end_q && (cursor_q == g_rel)) begin
					if (g_rel == '1) begin
						at_end_q <= 1'b1;
					end else begin
						wcnt_q  <= '0;
						wbase_q <= g_rel + GW'(1);
						wlim_q  <= WW'(NUM_GROUPS - 1) - WW'(g_rel);
					end
				end
			end
			if (cmd.upd_div) begin
				wcnt_q   <= '0;
				wbase_q  <= at_end_q ? '0 : cursor_q;
				wlim_q   <= WW'(NUM_GROUPS);
				sum_q    <= '0;
				marked_q <= '0;
				sel_q    <= '0;
			end
			// Update walk: mark live groups until the sum passes the budget.
			if (cmd.walk_upd && wvld_s1 && live) begin
				sum_q          <= sum_nxt;
				marked_q       <= marked_q + 7'd1;
				sel_q[wgrp_s1] <= 1'b1;
				if (at_end_q || over) begin
					cursor_q <= wgrp_s1;
				end
				if (at_end_q) begin
					at_end_q <= 1'b0;
				end
			end
			// Cursor advance walk: first live group of higher id.
			if (cmd.walk_adv && wvld_s1) begin
				if (live) begin
					cursor_q <= wgrp_s1;
				end else if (wlast_s1) begin
					at_end_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers and result fields.
	always_ff @(posedge clk) begin
		wgrp_s1  <= walk_addr;
		wlast_s1 <= (wcnt_q == wlim_q - WW'(1));
		if (cmd.accept) begin
			item_q <= item;
			res_q  <= '0;
		end
		if (cmd.alloc_rd && ptr_q[PTR_W-1]) begin
			res_q.status <= ST_NO_FREE;
		end
		if (cmd.alloc_cnt) begin
			alloc_h_q <= alloc_a;
		end
		if (cmd.alloc_wr) begin
			res_q.new_handle <= alloc_h_q;
		end
		if (cmd.rel_wr && !rel_ok) begin
			res_q.status <= ST_BAD_REL;
		end
		if (cmd.upd_mul) begin
			mul_s1 <= {4'b0, sched_q} * {12'b0, fac};
		end
		if (cmd.upd_div) begin
			budget_q     <= bud_nxt;
			res_q.budget <= bud_nxt;
		end
		if (cmd.walk_upd && wvld_s1 && live) begin
			res_q.selected_groups <= marked_q + 7'd1;
		end
		if (cmd.query) begin
			res_q.skip <= !sel_q[g_rel];
		end
	end

	// Memories with registered read.
	always_ff @(posedge clk) begin
		stack_rd_q <= stack_mem[ptr_q[HW-1:0]];
		mark_rd_q  <= mark_mem[item_q.handle];
		cnt_rd_q   <= cnt_mem[cnt_raddr];
		if (cmd.rel_wr && rel_ok) begin
			stack_mem[ptr_m1[HW-1:0]] <= item_q.handle;
		end
		if (cmd.alloc_wr) begin
			mark_mem[alloc_h_q] <= 1'b1;
		end else if (cmd.rel_wr && rel_ok) begin
			mark_mem[item_q.handle] <= 1'b0;
		end
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
	end

	assign result = res_q;

endmodule

@@ rtl/brgs_ctrl.sv @@
// Controller: sequences each operation through the datapath.
`timescale 1ns / 1ps
module brgs_ctrl import brgs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	typedef enum logic [3:0] {
		S_IDLE, S_ALLOC_RD, S_ALLOC_CNT, S_ALLOC_WR, S_REL_RD, S_REL_WR,
		S_ADV, S_UPD_MUL, S_UPD_DIV, S_UPD_WALK, S_QRY
	} state_t;

	state_t state_q, state_nxt;
	logic   done_q, fin;

	// Command decode and next state.
	always_comb begin
		cmd       = '0;
		fin       = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = start;
				if (start) begin
					unique case (op_e'(sts.in_op))
						OP_ALLOC:   state_nxt = S_ALLOC_RD;
						OP_RELEASE: state_nxt = S_REL_RD;
						OP_UPDATE:  state_nxt = S_UPD_MUL;
						OP_QUERY:   state_nxt = S_QRY;
						default:    state_nxt = S_QRY;
					endcase
				end
			end
			S_ALLOC_RD: begin
				cmd.alloc_rd = 1'b1;
				if (sts.empty) begin
					fin       = 1'b1;
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_ALLOC_CNT;
				end
			end
			S_ALLOC_CNT: begin
				cmd.alloc_cnt = 1'b1;
				state_nxt     = S_ALLOC_WR;
			end
			S_ALLOC_WR: begin
				cmd.alloc_wr = 1'b1;
				fin          = 1'b1;
				state_nxt    = S_IDLE;
			end
			S_REL_RD: begin
				cmd.rel_rd = 1'b1;
				state_nxt  = S_REL_WR;
			end
			S_REL_WR: begin
				cmd.rel_wr = 1'b1;
				if (sts.adv_need) begin
					state_nxt = S_ADV;
				end else begin
					fin       = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_ADV: begin
				cmd.walk_issue = 1'b1;
				cmd.walk_adv   = 1'b1;
				if (sts.walk_done) begin
					fin       = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_UPD_MUL: begin
				cmd.upd_mul = 1'b1;
				state_nxt   = S_UPD_DIV;
			end
			S_UPD_DIV: begin
				cmd.upd_div = 1'b1;
				state_nxt   = S_UPD_WALK;
			end
			S_UPD_WALK: begin
				cmd.walk_issue = 1'b1;
				cmd.walk_upd   = 1'b1;
				if (sts.walk_done) begin
					fin       = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_QRY: begin
				cmd.query = 1'b1;
				fin       = 1'b1;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= fin;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
